// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define HBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define HBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/core/hbc_pkg.sv -----
// Types and constants of the humidifier burst controller
package hbc_pkg;
    localparam logic [31:0] SHORTEST_RUN_MS = 32'd5000;
    localparam logic [31:0] MAX_ACCRUE_MS = 32'd10000;
    localparam logic [12:0] PLATE_HYST    = 13'd3;

    typedef enum logic [1:0] {PH_IDLE = 2'd0, PH_PENDING = 2'd1, PH_RUNNING = 2'd2,
                              PH_SETTLING = 2'd3} phase_t;
    typedef enum logic [1:0] {TR_NONE = 2'd0, TR_DRY = 2'd1, TR_MANUAL = 2'd2} trig_t;

    typedef enum logic [3:0] {
        RS_IDLE = 4'd0, RS_SETTLING = 4'd1, RS_MANUAL = 4'd2, RS_DRY_CAPPED = 4'd3,
        RS_DRY_START = 4'd4, RS_DRY_COLD = 4'd5, RS_WITHDRAWN_WET = 4'd6,
        RS_WITHDRAWN_CAP = 4'd7, RS_PLATE_WARM = 4'd8, RS_WAIT_PLATE = 4'd9,
        RS_HUMIDIFYING = 4'd10, RS_BURST_DONE = 4'd11, RS_TARGET = 4'd12,
        RS_PLATE_COLD = 4'd13, RS_CAP_MID = 4'd14
    } reason_t;

    typedef enum logic [2:0] {
        CR_TARGET = 3'd0, CR_BAND = 3'd1, CR_CAP = 3'd2, CR_GATE = 3'd3,
        CR_BURST = 3'd4, CR_SETTLE = 3'd5
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        SQ_IDLE, SQ_ACCRUE, SQ_ROLL, SQ_CLEAR, SQ_SUM, SQ_DECIDE, SQ_OUT
    } seq_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [9:0]  humidity_raw;
        logic        humidity_raw_ok;
        logic [9:0]  humidity_mean;
        logic        humidity_mean_ok;
        logic        mean_in_use;
        logic signed [11:0] plate_temp;
        logic        plate_temp_ok;
        logic        plate_fitted;
        logic        manual_request;
    } tick_t;

    typedef struct packed {
        logic       fan_on;
        logic [1:0] phase_out;
        logic [1:0] trigger_out;
        logic [3:0] reason_code;
    } result_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [11:0] data;
    } cfg_t;
endpackage

// ----- rtl/core/hbc_stream_if.sv -----
// Valid/ready channel interfaces for ticks, results and register writes
interface hbc_tick_if;
    logic valid;
    logic ready;
    hbc_pkg::tick_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hbc_result_if;
    logic valid;
    logic ready;
    hbc_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hbc_cfg_if;
    logic valid;
    logic ready;
    hbc_pkg::cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/humidifier_burst_controller_core.sv -----
// Humidifier burst controller: one tick in, one result out.
// A tick runs through the accrue, roll, sum, decide and output states to its result; the
// window rolls bucket by bucket while the tick is a span or more past the window start,
// and a gap longer than the whole window sweeps every bucket clear. The next tick can be
// accepted as soon as the result appears. The duty buckets sit in a memory with one
// write port and a registered read port, and the sequencer reads-modifies-writes the
// current bucket, rolls the window one bucket a cycle, then reads every bucket once to sum
// it before the decision. After reset a clearing pass zeroes every bucket before the
// first tick is taken. A finished result waits in the output register while the next
// tick is accepted; that tick's decision holds until the register is free.
module humidifier_burst_controller_core #(
    parameter int BUCKET_COUNT   = 16,
    parameter int BUCKET_SPAN_MS = 60000
) (
    input  logic clk,
    input  logic rst_n,
    hbc_tick_if.sink     tick,
    hbc_result_if.source result,
    hbc_cfg_if.sink      cfg
);
    import hbc_pkg::*;

    localparam int IW = $clog2(BUCKET_COUNT);
    localparam logic [31:0] SPAN = 32'(BUCKET_SPAN_MS);
    localparam logic [IW:0] LAST = (IW+1)'(BUCKET_COUNT - 1);
    localparam logic [IW:0] CNT  = (IW+1)'(BUCKET_COUNT);
    // cap limit = duty_cap * BUCKET_COUNT*BUCKET_SPAN_MS, sum scaled by 1000
    localparam logic [31:0] WIN_MS = 32'(BUCKET_COUNT * BUCKET_SPAN_MS);

    logic [31:0] bucket_mem [BUCKET_COUNT];
    logic [31:0] rd_data;
    logic        wr_en;
    logic [IW-1:0] wr_addr, rd_addr;
    logic [31:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bucket_mem[wr_addr] <= wr_data;
        end
        rd_data <= bucket_mem[rd_addr];
    end

    // Configuration
    logic [9:0] target_reg, band_reg, cap_reg;
    logic signed [11:0] gate_reg;
    logic [11:0] burst_len_reg;
    logic [10:0] settle_reg;

    seq_t seq_reg, seq_next;
    phase_t phase_reg;
    trig_t trig_reg;
    logic manual_reg, had_burst_reg, fan_was_reg, seen_reg;
    logic [31:0] last_reg, bstart_reg, burst_start_reg, burst_end_reg;
    logic [IW-1:0] idx_reg;
    logic [IW:0] cnt_reg;
    logic [IW:0] rolled_reg;
    logic [41:0] sum_reg;
    tick_t in_reg;
    logic accrue_reg;
    logic [31:0] dt_reg;
    logic out_valid_reg;
    result_t out_reg;
    logic [51:0] sum_scaled_reg, limit_reg;

    assign cfg.ready    = 1'b1;
    assign tick.ready   = (seq_reg == SQ_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= 10'd750;
            band_reg      <= 10'd30;
            cap_reg       <= 10'd0;
            gate_reg      <= 12'sd0;
            burst_len_reg <= 12'd30;
            settle_reg    <= 11'd10;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.data.index))
                CR_TARGET: target_reg    <= cfg.data.data[9:0];
                CR_BAND:   band_reg      <= cfg.data.data[9:0];
                CR_CAP:    cap_reg       <= cfg.data.data[9:0];
                CR_GATE:   gate_reg      <= cfg.data.data;
                CR_BURST:  burst_len_reg <= cfg.data.data;
                CR_SETTLE: settle_reg    <= cfg.data.data[10:0];
                default: ;
            endcase
        end
    end

    logic tick_fire;
    assign tick_fire = tick.valid && tick.ready;
    logic [31:0] roll_gap;
    assign roll_gap = in_reg.now_ms - bstart_reg;

    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            // a sweep after a long gap carries on to the sum
            SQ_CLEAR:  if (cnt_reg == LAST) seq_next = seen_reg ? SQ_SUM : SQ_IDLE;
            SQ_IDLE:   if (tick_fire) seq_next = SQ_ACCRUE;
            SQ_ACCRUE: if (cnt_reg[0]) seq_next = SQ_ROLL;
            SQ_ROLL:
            begin
                if (roll_gap < SPAN) seq_next = SQ_SUM;
                else if (rolled_reg == LAST) seq_next = SQ_CLEAR;
            end
            SQ_SUM:
            begin
                // hold the decision while the previous result still waits
                if (cnt_reg == CNT + 1'b1 && (!out_valid_reg || result.ready))
                    seq_next = SQ_DECIDE;
            end
            SQ_DECIDE: seq_next = SQ_OUT;
            SQ_OUT:    seq_next = SQ_IDLE;
            default:   seq_next = SQ_IDLE;
        endcase
    end

    // Memory port control
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '0;
        rd_addr = idx_reg;
        case (seq_reg)
            SQ_CLEAR:
            begin
                wr_en = 1'b1;
                wr_addr = cnt_reg[IW-1:0];
            end
            SQ_ACCRUE:
            begin
                wr_en = cnt_reg[0] && accrue_reg;
                wr_data = ({1'b0, rd_data} + {1'b0, dt_reg} > 33'hFFFF_FFFF) ?
                          32'hFFFF_FFFF : rd_data + dt_reg;
            end
            SQ_ROLL:
            begin
                wr_en = (roll_gap >= SPAN) && (rolled_reg != LAST);
                wr_addr = (idx_reg == IW'(BUCKET_COUNT - 1)) ? '0 : idx_reg + 1'b1;
            end
            SQ_SUM:
            begin
                rd_addr = cnt_reg[IW-1:0];
            end
            default: ;
        endcase
    end

    // Decision combinational terms
    logic signed [11:0] raise_below;
    logic dry_req, dry_hold, plate_start, plate_hold, duty_ok;
    logic [31:0] settle_ms, burst_ms, el, since_end;
    assign raise_below = $signed({2'b00, target_reg}) - $signed({2'b00, band_reg});
    assign dry_req = in_reg.mean_in_use ?
        (in_reg.humidity_mean_ok && $signed({2'b00, in_reg.humidity_mean}) <= raise_below) :
        (in_reg.humidity_raw_ok && $signed({2'b00, in_reg.humidity_raw}) <= raise_below);
    assign dry_hold = !in_reg.humidity_raw_ok || (in_reg.humidity_raw < target_reg);
    assign plate_start = !in_reg.plate_fitted ||
        (in_reg.plate_temp_ok && $signed(in_reg.plate_temp) >= gate_reg);
    assign plate_hold = manual_reg || !in_reg.plate_fitted || (in_reg.plate_temp_ok &&
        $signed({in_reg.plate_temp[11], in_reg.plate_temp}) >=
        $signed({gate_reg[11], gate_reg}) - $signed(PLATE_HYST));
    assign settle_ms = settle_reg * 32'd60000;
    assign burst_ms  = burst_len_reg * 32'd1000;
    assign el        = in_reg.now_ms - burst_start_reg;
    assign since_end = in_reg.now_ms - burst_end_reg;
    assign duty_ok   = (cap_reg == '0) || (sum_scaled_reg < limit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= SQ_CLEAR;
            cnt_reg <= '0;
            phase_reg <= PH_IDLE;
            trig_reg <= TR_NONE;
            manual_reg <= 1'b0;
            had_burst_reg <= 1'b0;
            fan_was_reg <= 1'b0;
            seen_reg <= 1'b0;
            last_reg <= '0;
            bstart_reg <= '0;
            burst_start_reg <= '0;
            burst_end_reg <= '0;
            idx_reg <= '0;
            rolled_reg <= '0;
            out_valid_reg <= 1'b0;
            accrue_reg <= 1'b0;
        end
        else
        begin
            seq_reg <= seq_next;
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (seq_reg)
                SQ_CLEAR:
                begin
                    cnt_reg <= (cnt_reg == LAST) ? '0 : cnt_reg + 1'b1;
                end
                SQ_IDLE:
                begin
                    if (tick_fire)
                    begin
                        logic [31:0] lt, dt;
                        lt = seen_reg ? last_reg : tick.data.now_ms;
                        dt = tick.data.now_ms - lt;
                        if (!seen_reg)
                        begin
                            bstart_reg <= tick.data.now_ms;
                        end
                        seen_reg   <= 1'b1;
                        dt_reg     <= dt;
                        accrue_reg <= fan_was_reg && (dt <= MAX_ACCRUE_MS);
                        last_reg   <= tick.data.now_ms;
                        cnt_reg    <= '0;
                        rolled_reg <= '0;
                    end
                end
                SQ_ACCRUE:
                begin
                    // wait for the registered bucket read, then write back
                    cnt_reg <= cnt_reg[0] ? '0 : cnt_reg + 1'b1;
                end
                SQ_ROLL:
                begin
                    if (roll_gap >= SPAN)
                    begin
                        if (rolled_reg == LAST)
                        begin
                            bstart_reg <= in_reg.now_ms;
                            idx_reg <= '0;
                            cnt_reg <= '0;
                            sum_reg <= '0;
                        end
                        else
                        begin
                            bstart_reg <= bstart_reg + SPAN;
                            idx_reg <= (idx_reg == IW'(BUCKET_COUNT - 1)) ? '0 : idx_reg + 1'b1;
                            rolled_reg <= rolled_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_reg <= '0;
                        sum_reg <= '0;
                    end
                end
                SQ_SUM:
                begin
                    // read data is registered and lags the address
                    if (cnt_reg != '0 && cnt_reg <= CNT)
                    begin
                        sum_reg <= sum_reg + {10'd0, rd_data};
                    end
                    cnt_reg <= (cnt_reg == CNT + 1'b1) ? cnt_reg : cnt_reg + 1'b1;
                    if (cnt_reg == CNT + 1'b1)
                    begin
                        sum_scaled_reg <= {10'd0, sum_reg} * 52'd1000;
                        limit_reg <= {42'd0, cap_reg} * {20'd0, WIN_MS};
                    end
                end
                SQ_DECIDE:
                begin
                    logic fan;
                    reason_t rs;
                    phase_t ph;
                    trig_t tr;
                    fan = 1'b0;
                    rs = RS_IDLE;
                    ph = phase_reg;
                    tr = trig_reg;
                    case (phase_reg)
                        PH_IDLE, PH_PENDING, PH_SETTLING:
                        begin
                            if (in_reg.manual_request)
                            begin
                                ph = PH_RUNNING; tr = TR_MANUAL;
                                burst_start_reg <= in_reg.now_ms;
                                manual_reg <= 1'b1; fan = 1'b1; rs = RS_MANUAL;
                            end
                            else if (phase_reg == PH_IDLE)
                            begin
                                if (had_burst_reg && since_end < settle_ms)
                                begin
                                    ph = PH_SETTLING; rs = RS_SETTLING;
                                end
                                else if (!dry_req) rs = RS_IDLE;
                                else if (!duty_ok) rs = RS_DRY_CAPPED;
                                else
                                begin
                                    tr = TR_DRY;
                                    if (plate_start)
                                    begin
                                        ph = PH_RUNNING;
                                        burst_start_reg <= in_reg.now_ms;
                                        manual_reg <= 1'b0; fan = 1'b1; rs = RS_DRY_START;
                                    end
                                    else
                                    begin
                                        ph = PH_PENDING; rs = RS_DRY_COLD;
                                    end
                                end
                            end
                            else if (phase_reg == PH_PENDING)
                            begin
                                if (trig_reg == TR_DRY && !dry_hold)
                                begin
                                    ph = PH_IDLE; tr = TR_NONE; rs = RS_WITHDRAWN_WET;
                                end
                                else if (!duty_ok)
                                begin
                                    ph = PH_IDLE; tr = TR_NONE; rs = RS_WITHDRAWN_CAP;
                                end
                                else if (plate_start)
                                begin
                                    ph = PH_RUNNING;
                                    burst_start_reg <= in_reg.now_ms;
                                    manual_reg <= 1'b0; fan = 1'b1; rs = RS_PLATE_WARM;
                                end
                                else rs = RS_WAIT_PLATE;
                            end
                            else
                            begin
                                if (since_end >= settle_ms)
                                begin
                                    ph = PH_IDLE; rs = RS_IDLE;
                                end
                                else rs = RS_SETTLING;
                            end
                        end
                        default:
                        begin
                            if (el < SHORTEST_RUN_MS)
                            begin
                                fan = 1'b1; rs = RS_HUMIDIFYING;
                            end
                            else
                            begin
                                if (el >= burst_ms) rs = RS_BURST_DONE;
                                else if (trig_reg == TR_DRY && !dry_hold) rs = RS_TARGET;
                                else if (!plate_hold) rs = RS_PLATE_COLD;
                                else if (!duty_ok) rs = RS_CAP_MID;
                                else rs = RS_HUMIDIFYING;
                                if (rs == RS_HUMIDIFYING) fan = 1'b1;
                                else
                                begin
                                    ph = PH_SETTLING; tr = TR_NONE;
                                    burst_end_reg <= in_reg.now_ms;
                                    had_burst_reg <= 1'b1; manual_reg <= 1'b0;
                                end
                            end
                        end
                    endcase
                    phase_reg <= ph;
                    trig_reg <= tr;
                    fan_was_reg <= fan;
                    out_reg.fan_on <= fan;
                    out_reg.phase_out <= ph;
                    out_reg.trigger_out <= (fan || ph == PH_PENDING) ? tr : TR_NONE;
                    out_reg.reason_code <= rs;
                end
                SQ_OUT:
                begin
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            in_reg <= tick.data;
        end
    end
endmodule

// ----- rtl/core/hbc_checker.sv -----
// Port-level checker for the humidifier burst controller, bound into the core module
`include "assert_macros.svh"
module hbc_checker (
    input logic clk,
    input logic rst_n,
    input logic tick_valid,
    input logic tick_ready,
    input logic res_valid,
    input logic res_ready,
    input hbc_pkg::result_t res_data
);
    import hbc_pkg::*;
    `HBC_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_data), "result dropped while stalled")
    `HBC_ASSERT_IMP(a_fan_trig, clk, rst_n, res_valid && res_data.fan_on, res_data.trigger_out != TR_NONE, "fan on without trigger")
    `HBC_ASSERT_IMP(a_idle_fan, clk, rst_n, res_valid && res_data.phase_out == PH_IDLE, !res_data.fan_on, "fan on while idle")
    `HBC_ASSERT_NXT(a_one_tick, clk, rst_n, tick_valid && tick_ready, !tick_ready, "second tick taken while busy")
endmodule

bind humidifier_burst_controller_core hbc_checker u_hbc_checker (
    .clk(clk), .rst_n(rst_n), .tick_valid(tick.valid), .tick_ready(tick.ready),
    .res_valid(result.valid), .res_ready(result.ready), .res_data(result.data)
);

// ----- test/humidifier_burst_controller_core_tb.sv -----
// Self-checking testbench of the humidifier burst controller: directed and random ticks
module humidifier_burst_controller_core_tb;
    import hbc_pkg::*;

    localparam int          N_BUCKETS  = 16;
    localparam logic [31:0] SPAN_MS    = 32'd60000;
    localparam int          CYCLE_CAP  = 1500000;
    localparam int          DRAIN_WAIT = 80;

    class burst_scoreboard;
        // register copies
        logic [9:0]  target, band, cap;
        int          gate;
        logic [11:0] burst_s;
        logic [10:0] settle_min;
        // machine copy
        phase_t      phase;
        trig_t       trig;
        bit          forced, burst_seen, fan_was, clock_seen;
        logic [31:0] last_ms, win_start, burst_t0, burst_t1;
        int          win_idx;
        logic [31:0] bucket[N_BUCKETS];
        result_t     pending_results[$];
        int          errors;

        function new();
            target = 750; band = 30; cap = 0; gate = 0; burst_s = 30; settle_min = 10;
            phase = PH_IDLE; trig = TR_NONE;
            forced = 0; burst_seen = 0; fan_was = 0; clock_seen = 0;
            last_ms = 0; win_start = 0; burst_t0 = 0; burst_t1 = 0; win_idx = 0;
            foreach (bucket[i]) bucket[i] = 0;
            errors = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, int val);
            case (idx)
                CR_TARGET: target = val[9:0];
                CR_BAND:   band = val[9:0];
                CR_CAP:    cap = val[9:0];
                CR_GATE:   gate = $signed(val[11:0]);
                CR_BURST:  burst_s = val[11:0];
                CR_SETTLE: settle_min = val[10:0];
                default: ;
            endcase
        endfunction

        function bit cap_allows();
            longint unsigned total;
            total = 0;
            if (cap == 0)
                return 1;
            foreach (bucket[i]) total += bucket[i];
            return total * 1000 < longint'(cap) * N_BUCKETS * SPAN_MS;
        endfunction

        function void start_manual(logic [31:0] now);
            phase = PH_RUNNING; trig = TR_MANUAL; burst_t0 = now; forced = 1;
        endfunction

        function void note_tick(tick_t t);
            logic [31:0] now, dt, el, settle_ms, burst_ms;
            logic [32:0] sum;
            int          below, raw, mean, plate, k;
            bit          dry_req, dry_hold, pstart, phold, fan;
            reason_t     why;
            result_t     r;
            now = t.now_ms;
            raw = t.humidity_raw;
            mean = t.humidity_mean;
            plate = $signed(t.plate_temp);
            below = int'(target) - int'(band);
            dry_req = t.mean_in_use ? (t.humidity_mean_ok && mean <= below)
                                    : (t.humidity_raw_ok && raw <= below);
            dry_hold = !t.humidity_raw_ok || raw < int'(target);
            pstart = !t.plate_fitted || (t.plate_temp_ok && plate >= gate);
            settle_ms = settle_min * 32'd60000;
            burst_ms = burst_s * 32'd1000;
            fan = 0;
            why = RS_IDLE;
            if (!clock_seen)
            begin
                clock_seen = 1; last_ms = now; win_start = now;
            end
            // credit on time for short gaps only
            dt = now - last_ms;
            if (fan_was && dt <= MAX_ACCRUE_MS)
            begin
                sum = {1'b0, bucket[win_idx]} + dt;
                bucket[win_idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            last_ms = now;
            // roll the window, sweep clear after a full lap
            k = 0;
            dt = now - win_start;
            while (dt >= SPAN_MS)
            begin
                win_start += SPAN_MS;
                win_idx = (win_idx + 1) % N_BUCKETS;
                bucket[win_idx] = 0;
                k++;
                if (k >= N_BUCKETS)
                begin
                    foreach (bucket[i]) bucket[i] = 0;
                    win_start = now; win_idx = 0;
                    break;
                end
                dt = now - win_start;
            end
            case (phase)
                PH_IDLE:
                begin
                    if (t.manual_request)
                    begin
                        start_manual(now); fan = 1; why = RS_MANUAL;
                    end
                    else if (burst_seen && (now - burst_t1) < settle_ms)
                    begin
                        phase = PH_SETTLING; why = RS_SETTLING;
                    end
                    else if (!dry_req)
                        why = RS_IDLE;
                    else if (!cap_allows())
                        why = RS_DRY_CAPPED;
                    else
                    begin
                        trig = TR_DRY;
                        if (pstart)
                        begin
                            phase = PH_RUNNING; burst_t0 = now; forced = 0;
                            fan = 1; why = RS_DRY_START;
                        end
                        else
                        begin
                            phase = PH_PENDING; why = RS_DRY_COLD;
                        end
                    end
                end
                PH_PENDING:
                begin
                    if (t.manual_request)
                    begin
                        start_manual(now); fan = 1; why = RS_MANUAL;
                    end
                    else if (trig == TR_DRY && !dry_hold)
                    begin
                        phase = PH_IDLE; trig = TR_NONE; why = RS_WITHDRAWN_WET;
                    end
                    else if (!cap_allows())
                    begin
                        phase = PH_IDLE; trig = TR_NONE; why = RS_WITHDRAWN_CAP;
                    end
                    else if (pstart)
                    begin
                        phase = PH_RUNNING; burst_t0 = now; forced = 0;
                        fan = 1; why = RS_PLATE_WARM;
                    end
                    else
                        why = RS_WAIT_PLATE;
                end
                PH_RUNNING:
                begin
                    el = now - burst_t0;
                    phold = forced || !t.plate_fitted
                            || (t.plate_temp_ok && plate >= gate - 3);
                    why = RS_HUMIDIFYING;
                    if (el >= SHORTEST_RUN_MS)
                    begin
                        if (el >= burst_ms)
                            why = RS_BURST_DONE;
                        else if (trig == TR_DRY && !dry_hold)
                            why = RS_TARGET;
                        else if (!phold)
                            why = RS_PLATE_COLD;
                        else if (!cap_allows())
                            why = RS_CAP_MID;
                    end
                    if (why != RS_HUMIDIFYING)
                    begin
                        phase = PH_SETTLING; trig = TR_NONE; burst_t1 = now;
                        burst_seen = 1; forced = 0;
                    end
                    else
                        fan = 1;
                end
                default:
                begin
                    if (t.manual_request)
                    begin
                        start_manual(now); fan = 1; why = RS_MANUAL;
                    end
                    else if ((now - burst_t1) >= settle_ms)
                    begin
                        phase = PH_IDLE; why = RS_IDLE;
                    end
                    else
                        why = RS_SETTLING;
                end
            endcase
            r.fan_on = fan;
            r.phase_out = phase;
            r.trigger_out = (fan || phase == PH_PENDING) ? trig : TR_NONE;
            r.reason_code = why;
            fan_was = fan;
            pending_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.fan_on !== want.fan_on)
            begin
                $error("fan_on: expected %0d, got %0d", want.fan_on, got.fan_on);
                errors++;
            end
            if (got.phase_out !== want.phase_out)
            begin
                $error("phase_out: expected %0d, got %0d", want.phase_out, got.phase_out);
                errors++;
            end
            if (got.trigger_out !== want.trigger_out)
            begin
                $error("trigger_out: expected %0d, got %0d", want.trigger_out,
                       got.trigger_out);
                errors++;
            end
            if (got.reason_code !== want.reason_code)
            begin
                $error("reason_code: expected %0d, got %0d", want.reason_code,
                       got.reason_code);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    bit   steady;
    logic [31:0] clock_ms;
    burst_scoreboard sb;

    hbc_tick_if   tick_ch();
    hbc_result_if result_ch();
    hbc_cfg_if    cfg_ch();

    humidifier_burst_controller_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: random stalls, check every beat
    initial
    begin
        int hold;
        result_ch.ready = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.data);

    task automatic send_tick(tick_t t);
        int gap;
        @(negedge clk);
        tick_ch.valid <= 1'b1;
        tick_ch.data <= t;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        sb.note_tick(t);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            tick_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, int val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.data <= val[11:0];
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic directed(logic [31:0] now, int raw, bit raw_ok, int mean, bit mean_ok,
                            bit use_mean, int plate, bit plate_ok, bit fitted, bit man);
        tick_t t;
        t.now_ms = now;
        t.humidity_raw = raw[9:0];
        t.humidity_raw_ok = raw_ok;
        t.humidity_mean = mean[9:0];
        t.humidity_mean_ok = mean_ok;
        t.mean_in_use = use_mean;
        t.plate_temp = plate[11:0];
        t.plate_temp_ok = plate_ok;
        t.plate_fitted = fitted;
        t.manual_request = man;
        send_tick(t);
    endtask

    // random tick with values clustered round the current thresholds
    function automatic tick_t rand_tick();
        tick_t t;
        int r, thr, v;
        r = $urandom_range(0, 99);
        if (r < 70)
            clock_ms += $urandom_range(100, 4000);
        else if (r < 88)
            clock_ms += $urandom_range(4001, 70000);
        else if (r < 94)
            clock_ms += $urandom_range(60000, 3000000);
        else if (r < 97)
            clock_ms -= $urandom_range(1, 100000);
        else
            clock_ms = $urandom;
        t.now_ms = clock_ms;
        thr = int'(sb.target) - int'(sb.band);
        v = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1000)
                                         : thr + $urandom_range(0, 80) - 40;
        t.humidity_raw = (v < 0) ? 10'd0 : (v > 1000) ? 10'd1000 : v[9:0];
        v = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1000)
                                         : thr + $urandom_range(0, 80) - 40;
        t.humidity_mean = (v < 0) ? 10'd0 : (v > 1000) ? 10'd1000 : v[9:0];
        t.humidity_raw_ok = $urandom_range(0, 9) != 0;
        t.humidity_mean_ok = $urandom_range(0, 9) != 0;
        t.mean_in_use = $urandom_range(0, 2) == 0;
        v = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 1800)) - 550
                                         : sb.gate + $urandom_range(0, 12) - 6;
        v = (v < -550) ? -550 : (v > 1250) ? 1250 : v;
        t.plate_temp = v[11:0];
        t.plate_temp_ok = $urandom_range(0, 9) != 0;
        t.plate_fitted = $urandom_range(0, 1) != 0;
        t.manual_request = $urandom_range(0, 19) == 0;
        return t;
    endfunction

    initial
    begin
        int settings[5][6];
        int counts[5];
        sb = new();
        cycles = 0;
        steady = 0;
        rst_n = 1'b0;
        tick_ch.valid = 1'b0;
        tick_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        settings = '{'{1000, 0, 1000, -550, 0, 0},
                     '{600, 30, 5, 0, 20, 1},
                     '{0, 1000, 1, 1250, 3600, 1440},
                     '{700, 50, 0, 200, 10, 0},
                     '{750, 30, 300, -100, 15, 1}};
        counts = '{120, 150, 40, 150, 170};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part under reset register values (dry threshold 720)
        directed(32'd1000, 1000, 1, 0, 0, 0, 0, 0, 0, 0);     // wet, idle
        directed(32'd2000, 0, 1, 0, 0, 0, -550, 1, 1, 0);     // dry, plate cold
        directed(32'd3000, 760, 1, 0, 0, 0, -550, 1, 1, 0);   // withdrawn, wet
        directed(32'd4000, 700, 1, 0, 0, 0, -550, 1, 1, 0);   // pending again
        directed(32'd4500, 700, 1, 0, 0, 0, 100, 0, 1, 0);    // probe invalid: wait
        directed(32'd5000, 700, 0, 0, 0, 0, 1250, 1, 1, 0);   // plate warm, start
        directed(32'd6000, 800, 1, 0, 0, 0, 1250, 1, 1, 0);   // within minimum on
        directed(32'd11000, 800, 1, 0, 0, 0, 1250, 1, 1, 0);  // target reached
        directed(32'd12000, 900, 1, 0, 0, 0, 0, 1, 0, 1);     // manual from settling
        directed(32'd20000, 900, 1, 0, 0, 0, -550, 1, 1, 0);  // forced burst ignores plate
        directed(32'd40000, 900, 1, 0, 0, 0, -550, 1, 1, 1);
        directed(32'd43000, 900, 1, 0, 0, 0, -550, 1, 1, 0);  // burst complete
        directed(32'd60000, 0, 1, 0, 0, 0, 0, 0, 0, 0);       // still settling
        directed(32'd643000, 0, 1, 1000, 1, 1, 0, 0, 0, 0);   // settle over, mean wet
        directed(32'd644000, 1000, 1, 0, 0, 1, 0, 1, 1, 0);   // mean unsettled
        directed(32'd645000, 0, 1, 0, 1, 1, 0, 1, 1, 0);      // dry by mean, start
        directed(32'd651000, 0, 1, 0, 1, 1, -3, 1, 1, 0);     // inside stop hysteresis
        directed(32'd652000, 0, 1, 0, 1, 1, -4, 1, 1, 0);     // plate fell below gate minus hysteresis
        directed(32'd640000, 0, 1, 0, 1, 1, 0, 1, 1, 0);      // clock ran backwards
        directed(32'hFFFF_F000, 0, 0, 0, 0, 0, 0, 0, 0, 1);   // long gap, manual
        directed(32'h0000_0800, 1023, 1, 1023, 1, 0, 2047, 1, 1, 0); // wraps past zero
        directed(32'h0000_2000, 0, 1, 0, 1, 0, -2048, 1, 1, 0);
        drain();

        clock_ms = 32'd1000;
        foreach (counts[p])
        begin
            for (int i = 0; i < 6; i++)
                write_reg(cfg_reg_t'(i), settings[p][i]);
            for (int n = 0; n < counts[p]; n++)
            begin
                if (n % 40 == 0)
                    steady = $urandom_range(0, 3) == 0;
                send_tick(rand_tick());
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/hbc_pkg.sv
rtl/core/hbc_stream_if.sv
rtl/core/humidifier_burst_controller_core.sv
rtl/core/hbc_checker.sv
test/humidifier_burst_controller_core_tb.sv
